[src/mgrf_pkg.sv]
// Shared types, constants and helper functions of the minimum good-run filter.
`default_nettype none

package mgrf_pkg;

  localparam int MaxRun    = 32;
  localparam int Channels  = 8;
  localparam int NumFields = 8;
  localparam int SampleW   = 32;
  localparam int MinRunW   = 6;
  localparam int ChanCntW  = 4;
  localparam int CfgIdxW   = 2;
  localparam int AddrW     = (MaxRun > 1) ? $clog2(MaxRun) : 1;
  localparam int CntW      = $clog2(MaxRun + 2);
  localparam int RowW      = Channels * SampleW;

  localparam logic [CfgIdxW-1:0] CfgMinRun    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBadValue  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChanCount = 2'd2;

  typedef logic [Channels-1:0][SampleW-1:0] row_t;

  typedef struct packed {
    logic signed [SampleW-1:0] ch0;
    logic signed [SampleW-1:0] ch1;
    logic signed [SampleW-1:0] ch2;
    logic signed [SampleW-1:0] ch3;
    logic signed [SampleW-1:0] ch4;
    logic signed [SampleW-1:0] ch5;
    logic signed [SampleW-1:0] ch6;
    logic signed [SampleW-1:0] ch7;
    logic                      final_row;
  } row_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out0;
    logic signed [SampleW-1:0] out1;
    logic signed [SampleW-1:0] out2;
    logic signed [SampleW-1:0] out3;
    logic signed [SampleW-1:0] out4;
    logic signed [SampleW-1:0] out5;
    logic signed [SampleW-1:0] out6;
    logic signed [SampleW-1:0] out7;
    logic                      batch_end;
    logic                      stream_end;
    logic                      too_short;
  } row_out_t;

  typedef struct packed {
    logic [MinRunW-1:0]  min_run;
    logic [SampleW-1:0]  bad_value;
    logic [ChanCntW-1:0] chan_cnt;
  } cfg_t;

  // One result handed from the sequencer to the output stage.
  typedef struct packed {
    logic valid;
    logic from_mem;
    row_t data;
    logic batch_end;
    logic stream_end;
    logic too_short;
  } issue_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    MODE_BAD,
    MODE_MEM,
    MODE_ROW
  } emit_mode_e;

  function automatic logic [CntW-1:0] eff_min(logic [MinRunW-1:0] m);
    logic [CntW-1:0] r;
    if (m == '0) begin
      r = CntW'(1);
    end else if (int'(m) > MaxRun) begin
      r = CntW'(MaxRun);
    end else begin
      r = CntW'(m);
    end
    return r;
  endfunction

  function automatic logic [ChanCntW-1:0] eff_chans(logic [ChanCntW-1:0] c);
    logic [ChanCntW-1:0] r;
    if (c == '0) begin
      r = ChanCntW'(1);
    end else if (int'(c) > Channels) begin
      r = ChanCntW'(Channels);
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic row_t to_row(row_in_t d);
    logic [NumFields-1:0][SampleW-1:0] all;
    row_t r;
    all = {d.ch7, d.ch6, d.ch5, d.ch4, d.ch3, d.ch2, d.ch1, d.ch0};
    for (int j = 0; j < Channels; j++) begin
      r[j] = all[j];
    end
    return r;
  endfunction

  // Channels at or above the channel count read as zero.
  function automatic row_out_t to_out(row_t r, logic [ChanCntW-1:0] nchan,
                                      logic be, logic se, logic ts);
    logic [NumFields-1:0][SampleW-1:0] all;
    row_out_t o;
    all = '0;
    for (int j = 0; j < Channels; j++) begin
      if (j < int'(nchan)) begin
        all[j] = r[j];
      end
    end
    o.out0       = all[0];
    o.out1       = all[1];
    o.out2       = all[2];
    o.out3       = all[3];
    o.out4       = all[4];
    o.out5       = all[5];
    o.out6       = all[6];
    o.out7       = all[7];
    o.batch_end  = be;
    o.stream_end = se;
    o.too_short  = ts;
    return o;
  endfunction

endpackage

`default_nettype wire

[src/mgrf_if.sv]
// Valid/ready stream interfaces for input rows and released rows.
`default_nettype none

interface mgrf_in_if;
  logic              valid;
  logic              ready;
  mgrf_pkg::row_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mgrf_out_if;
  logic               valid;
  logic               ready;
  mgrf_pkg::row_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/mgrf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mgrf_ram #(
  parameter int Width = 256,
  parameter int Depth = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/mgrf_seq.sv]
// Run tracking and result sequencer: classifies each row and issues its results.
`default_nettype none

module mgrf_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mgrf_pkg::cfg_t                cfg_i,
  mgrf_in_if.sink                            row_i,
  input  wire logic                          issue_ready_i,
  output      mgrf_pkg::issue_t              issue_o,
  output      logic                          ram_we_o,
  output      logic [mgrf_pkg::AddrW-1:0]    ram_waddr_o,
  output      mgrf_pkg::row_t                ram_wdata_o,
  output      logic                          ram_re_o,
  output      logic [mgrf_pkg::AddrW-1:0]    ram_raddr_o
);

  mgrf_pkg::seq_state_e             state_q, state_d;
  mgrf_pkg::emit_mode_e             mode_q, mode_d;
  logic [mgrf_pkg::CntW-1:0]        held_q, held_d;
  logic [mgrf_pkg::CntW-1:0]        total_q, total_d;
  logic [mgrf_pkg::CntW-1:0]        idx_q;
  logic [mgrf_pkg::MinRunW-1:0]     seen_q, seen_d;
  logic                             passed_q, passed_d;
  logic                             final_q;
  logic                             short_q;
  mgrf_pkg::row_t                   row_q;

  mgrf_pkg::row_t                   row_in;
  mgrf_pkg::row_t                   bad_row;
  logic                             accept;
  logic                             is_bad;
  logic                             hold_full;
  logic                             short_in;
  logic                             last;
  logic                             fire;
  logic [mgrf_pkg::CntW-1:0]        held_new;
  logic [mgrf_pkg::MinRunW-1:0]     seen_inc;

  assign row_i.ready = (state_q == mgrf_pkg::SEQ_IDLE);
  assign accept      = row_i.valid && row_i.ready;
  assign row_in      = mgrf_pkg::to_row(row_i.data);
  assign is_bad      = (row_in[0] == cfg_i.bad_value);
  assign hold_full   = (held_q == mgrf_pkg::CntW'(mgrf_pkg::MaxRun));
  assign held_new    = hold_full ? held_q : held_q + 1'b1;
  assign seen_inc    = (seen_q < cfg_i.min_run) ? seen_q + 1'b1 : seen_q;
  assign short_in    = (seen_inc < cfg_i.min_run);

  always_comb begin
    for (int j = 0; j < mgrf_pkg::Channels; j++) begin
      bad_row[j] = cfg_i.bad_value;
    end
  end

  // Decide what the accepted row produces and how the run state moves on.
  always_comb begin
    mode_d   = mgrf_pkg::MODE_ROW;
    total_d  = '0;
    held_d   = held_q;
    passed_d = passed_q;
    if (is_bad) begin
      mode_d   = mgrf_pkg::MODE_BAD;
      total_d  = held_q + 1'b1;
      held_d   = '0;
      passed_d = 1'b0;
    end else if (passed_q) begin
      mode_d  = mgrf_pkg::MODE_ROW;
      total_d = mgrf_pkg::CntW'(1);
    end else if (held_new >= mgrf_pkg::eff_min(cfg_i.min_run)) begin
      mode_d   = mgrf_pkg::MODE_MEM;
      total_d  = held_new;
      held_d   = '0;
      passed_d = 1'b1;
    end else if (row_i.data.final_row) begin
      // A run still too short at the end of the data set goes out as bad.
      mode_d  = mgrf_pkg::MODE_BAD;
      total_d = held_new;
      held_d  = '0;
    end else begin
      held_d = held_new;
    end
    if (row_i.data.final_row) begin
      passed_d = 1'b0;
      seen_d   = '0;
    end else begin
      seen_d = seen_inc;
    end
  end

  assign last = (idx_q == total_q - 1'b1);
  assign fire = (state_q == mgrf_pkg::SEQ_EMIT) && issue_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mgrf_pkg::SEQ_IDLE: begin
        if (accept && (total_d != '0)) begin
          state_d = mgrf_pkg::SEQ_EMIT;
        end
      end
      mgrf_pkg::SEQ_EMIT: begin
        if (fire && last) begin
          state_d = mgrf_pkg::SEQ_IDLE;
        end
      end
      default: state_d = mgrf_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    issue_o.valid      = fire;
    issue_o.from_mem   = (mode_q == mgrf_pkg::MODE_MEM);
    issue_o.data       = (mode_q == mgrf_pkg::MODE_BAD) ? bad_row : row_q;
    issue_o.batch_end  = last;
    issue_o.stream_end = last && final_q;
    issue_o.too_short  = last && final_q && short_q;
    ram_re_o           = fire && (mode_q == mgrf_pkg::MODE_MEM);
    ram_raddr_o        = idx_q[mgrf_pkg::AddrW-1:0];
    ram_we_o           = accept && !is_bad && !passed_q && !hold_full;
    ram_waddr_o        = held_q[mgrf_pkg::AddrW-1:0];
    ram_wdata_o        = row_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mgrf_pkg::SEQ_IDLE;
      mode_q   <= mgrf_pkg::MODE_ROW;
      held_q   <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      seen_q   <= '0;
      passed_q <= 1'b0;
      final_q  <= 1'b0;
      short_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        total_q  <= total_d;
        idx_q    <= '0;
        seen_q   <= seen_d;
        passed_q <= passed_d;
        final_q  <= row_i.data.final_row;
        short_q  <= short_in;
      end else if (fire) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= row_in;
    end
  end

endmodule

`default_nettype wire

[src/mgrf_outq.sv]
// Output stage: RAM read alignment, channel masking and a two-entry result queue.
`default_nettype none

module mgrf_outq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [mgrf_pkg::ChanCntW-1:0]  nchan_i,
  input  wire mgrf_pkg::issue_t               issue_i,
  input  wire mgrf_pkg::row_t                 rdata_i,
  output      logic                           issue_ready_o,
  mgrf_out_if.source                          row_o
);

  mgrf_pkg::issue_t   s1_q;
  mgrf_pkg::row_out_t ent_q [2];
  mgrf_pkg::row_out_t push_beat;
  logic               rd_ptr_q;
  logic               wr_ptr_q;
  logic [1:0]         occ_q, occ_d;
  logic [2:0]         occ_after;
  logic               push;
  logic               pop;

  assign push = s1_q.valid;
  assign pop  = row_o.valid && row_o.ready;

  assign push_beat = mgrf_pkg::to_out(s1_q.from_mem ? rdata_i : s1_q.data, nchan_i,
                                      s1_q.batch_end, s1_q.stream_end, s1_q.too_short);

  // A new issue is allowed only if the queue still has room once the beat in
  // flight through the read stage has landed.
  assign occ_after     = 3'(occ_q) + 3'(s1_q.valid) - 3'(pop);
  assign issue_ready_o = (occ_after < 3'd2);
  assign occ_d         = 2'(3'(occ_q) + 3'(push) - 3'(pop));

  assign row_o.valid = (occ_q != 2'd0);
  assign row_o.data  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      occ_q    <= 2'd0;
    end else begin
      s1_q  <= issue_i;
      occ_q <= occ_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_beat;
    end
  end

endmodule

`default_nettype wire

[src/minimum_good_run_filter.sv]
// Top level of the minimum good-run filter: configuration registers and wiring.
//
//   Port          Direction  Beat contents
//   row_i         in         ch0..ch7, final_row
//   row_o         out        out0..out7, batch_end, stream_end, too_short
//   cfg_*_i       in         register index and write data, no handshake
//
// A row that is only held is taken without a stall. A row that yields n
// results holds row_i.ready low until all are issued: the sequencer issues one
// result per cycle while the output stage has room, through the single read
// port of the held-row RAM; results pass the read stage and the queue to row_o.
// A stall on row_o stops issue once the two-entry result queue is full.
// Reset clears all run state; the held-row RAM needs no clearing pass.
`default_nettype none

module minimum_good_run_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mgrf_in_if.sink                            row_i,
  mgrf_out_if.source                         row_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mgrf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mgrf_pkg::SampleW-1:0]  cfg_data_i
);

  mgrf_pkg::cfg_t                  cfg_q;
  mgrf_pkg::issue_t                issue;
  mgrf_pkg::row_t                  ram_wdata;
  mgrf_pkg::row_t                  ram_rdata;
  logic                            issue_ready;
  logic                            ram_we;
  logic                            ram_re;
  logic [mgrf_pkg::AddrW-1:0]      ram_waddr;
  logic [mgrf_pkg::AddrW-1:0]      ram_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_run   <= mgrf_pkg::MinRunW'(1);
      cfg_q.bad_value <= mgrf_pkg::SampleW'(32767);
      cfg_q.chan_cnt  <= mgrf_pkg::ChanCntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mgrf_pkg::CfgMinRun:    cfg_q.min_run   <= cfg_data_i[mgrf_pkg::MinRunW-1:0];
        mgrf_pkg::CfgBadValue:  cfg_q.bad_value <= cfg_data_i;
        mgrf_pkg::CfgChanCount: cfg_q.chan_cnt  <= cfg_data_i[mgrf_pkg::ChanCntW-1:0];
        default: ;
      endcase
    end
  end

  mgrf_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .row_i         (row_i),
    .issue_ready_i (issue_ready),
    .issue_o       (issue),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  mgrf_ram #(
    .Width (mgrf_pkg::RowW),
    .Depth (mgrf_pkg::MaxRun)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mgrf_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nchan_i       (mgrf_pkg::eff_chans(cfg_q.chan_cnt)),
    .issue_i       (issue),
    .rdata_i       (ram_rdata),
    .issue_ready_o (issue_ready),
    .row_o         (row_o)
  );

endmodule

`default_nettype wire

[src/mgrf_chk.sv]
// Port-level checks on the released-row stream, bound to the top level.
`default_nettype none

module mgrf_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire mgrf_pkg::row_out_t out_data_i
);

  // A stalled beat stays put until it is taken.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("released beat changed while stalled");

  // The short-data-set flag only rides on the last beat of the data set.
  a_short_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.too_short |-> out_data_i.stream_end)
    else $error("too_short without stream_end");

  // The last beat of a data set always closes the batch of its row.
  a_end_closes_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.stream_end |-> out_data_i.batch_end)
    else $error("stream_end without batch_end");

endmodule

bind minimum_good_run_filter mgrf_chk u_mgrf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (row_o.valid),
  .out_ready_i (row_o.ready),
  .out_data_i  (row_o.data)
);

`default_nettype wire
